[rtl/hsvrgb_pkg.sv]
package hsvrgb_pkg;

  // Field widths
  localparam int HUE_W  = 14;
  localparam int PCT_W  = 7;
  localparam int RGB_W  = 16;
  localparam int CH_W   = 8;

  localparam int HUE_FRAC_BITS_DEF = 4;
  localparam int PCT_MAX           = 100;
  localparam int CH_MAX            = 255;

  // Pipeline stages
  localparam int NUM_STG   = 7;
  localparam int STG_WRAP  = 0;
  localparam int STG_SECT  = 1;
  localparam int STG_PROD  = 2;
  localparam int STG_SCALE = 3;
  localparam int STG_MIX   = 4;
  localparam int STG_RND   = 5;
  localparam int STG_OUT   = 6;

  // Hue wrap: 360 deg = 45 * 8, so the wrap is a mod-45 on the upper hue bits
  localparam int DEG_FRAC     = 3;
  localparam int HUE_MOD_ODD  = 45;
  localparam int UN_W         = 13;
  localparam int WRAP_SH      = 18;
  localparam int WRAP_RCP     = ((1 << WRAP_SH) + HUE_MOD_ODD - 1) / HUE_MOD_ODD;
  localparam int WQ_W         = 8;
  localparam int REM_W        = 6;
  localparam int DEG_W        = 9;
  localparam int DEG_PER_SECT = 60;
  localparam int DEGOFF_W     = 6;
  localparam int SEC_W        = 3;
  localparam int NUM_SECT     = 6;

  // Products and rounding; den = 600000 << frac bits, 2*den = 9375 << (frac + 7)
  localparam int    VS_W       = 14;
  localparam int    DEN_BASE   = 600000;
  localparam int    DEN_BASE_W = 20;
  localparam int    DEN_SH     = 7;
  localparam int    CHAN_SCALE = 510;
  localparam int    SCALE_W    = 9;
  localparam int    RND_ODD    = 9375;
  localparam int    QN_W       = 22;
  localparam int    RND_SH     = 37;
  localparam int    RND_RCP_W  = 24;
  localparam longint RND_RCP   = ((64'd1 << RND_SH) + RND_ODD - 1) / RND_ODD;
  localparam int    QCH_W      = 9;

  // Hue sectors
  localparam logic [SEC_W-1:0] SEC_R_TO_Y = 3'd0;
  localparam logic [SEC_W-1:0] SEC_Y_TO_G = 3'd1;
  localparam logic [SEC_W-1:0] SEC_G_TO_C = 3'd2;
  localparam logic [SEC_W-1:0] SEC_C_TO_B = 3'd3;
  localparam logic [SEC_W-1:0] SEC_B_TO_M = 3'd4;
  localparam logic [SEC_W-1:0] SEC_M_TO_R = 3'd5;

  // Channel slots
  localparam int NUM_CH = 3;
  localparam int CH_R   = 0;
  localparam int CH_G   = 1;
  localparam int CH_B   = 2;

  typedef struct packed {
    logic [NUM_STG-1:0] ld;
  } pipe_ctl_t;

endpackage

[rtl/hsvrgb_in_if.sv]
interface hsvrgb_in_if;
  import hsvrgb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue;
  logic [PCT_W-1:0]        saturation;
  logic [PCT_W-1:0]        brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[rtl/hsvrgb_out_if.sv]
interface hsvrgb_out_if;
  import hsvrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] rgb565;

  modport source (output valid, rgb565, input ready);
  modport sink   (input valid, rgb565, output ready);
endinterface

[rtl/hsvrgb_hue.sv]
module hsvrgb_hue #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  hsvrgb_pkg::pipe_ctl_t               ctl,
  input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
  input  logic [hsvrgb_pkg::PCT_W-1:0]        saturation,
  input  logic [hsvrgb_pkg::PCT_W-1:0]        brightness,
  output logic [hsvrgb_pkg::SEC_W-1:0]        sector,
  output logic [$clog2((hsvrgb_pkg::DEG_PER_SECT << HUE_FRAC_BITS) + 1)-1:0] frac,
  output logic [hsvrgb_pkg::PCT_W-1:0]        sat,
  output logic [hsvrgb_pkg::PCT_W-1:0]        bri
);
  import hsvrgb_pkg::*;

  localparam int WSH      = HUE_FRAC_BITS + DEG_FRAC;
  localparam int SECT     = DEG_PER_SECT << HUE_FRAC_BITS;
  localparam int SECT_W   = $clog2(SECT + 1);
  localparam int U_SPAN   = 1 << (HUE_W - 1 - WSH);
  localparam int WRAP_OFF = HUE_MOD_ODD * ((U_SPAN + HUE_MOD_ODD - 1) / HUE_MOD_ODD);
  localparam logic [WSH-1:0] LOW_MASK = WSH'((1 << HUE_FRAC_BITS) - 1);

  function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] p);
    return (p > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : p;
  endfunction

  // stage 0: split hue, upper part offset positive, reciprocal multiply by 1/45
  logic signed [HUE_W-1:0] hue_sh;
  logic [UN_W-1:0]         un;
  logic [2*UN_W-1:0]       wprod;
  logic [UN_W-1:0]         un_r;
  logic [WQ_W-1:0]         wq_r;
  logic [WSH-1:0]          low_r;
  logic [PCT_W-1:0]        sat0_r, bri0_r;

  assign hue_sh = hue >>> WSH;
  assign un     = UN_W'(hue_sh + HUE_W'(WRAP_OFF));
  assign wprod  = un * UN_W'(WRAP_RCP);

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_WRAP]) begin
      un_r   <= un;
      wq_r   <= wprod[WRAP_SH +: WQ_W];
      low_r  <= hue[WSH-1:0];
      sat0_r <= pct_clamp(saturation);
      bri0_r <= pct_clamp(brightness);
    end
  end

  // stage 1: remainder gives whole degrees, then sector and ramp position
  logic [UN_W-1:0]     rem_full;
  logic [DEG_W-1:0]    deg;
  logic [SEC_W-1:0]    sec;
  logic [DEGOFF_W-1:0] degoff;
  logic [SECT_W-1:0]   off;
  logic [SECT_W-1:0]   frac_nxt;
  logic [SEC_W-1:0]    sector_r;
  logic [SECT_W-1:0]   frac_r;
  logic [PCT_W-1:0]    sat_r, bri_r;

  assign rem_full = un_r - UN_W'(wq_r) * UN_W'(HUE_MOD_ODD);
  assign deg      = {rem_full[REM_W-1:0], low_r[WSH-1 -: DEG_FRAC]};

  always_comb begin
    sec = '0;
    for (int k = 1; k < NUM_SECT; k++) begin
      if (deg >= DEG_W'(k * DEG_PER_SECT)) begin
        sec = SEC_W'(k);
      end
    end
  end

  assign degoff   = DEGOFF_W'(deg - DEG_W'(sec) * DEG_W'(DEG_PER_SECT));
  assign off      = (SECT_W'(degoff) << HUE_FRAC_BITS) | SECT_W'(low_r & LOW_MASK);
  // falling ramp in odd sectors
  assign frac_nxt = sec[0] ? (SECT_W'(SECT) - off) : off;

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_SECT]) begin
      sector_r <= sec;
      frac_r   <= frac_nxt;
      sat_r    <= sat0_r;
      bri_r    <= bri0_r;
    end
  end

  assign sector = sector_r;
  assign frac   = frac_r;
  assign sat    = sat_r;
  assign bri    = bri_r;

endmodule

[rtl/hsvrgb_mix.sv]
module hsvrgb_mix #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  hsvrgb_pkg::pipe_ctl_t        ctl,
  input  logic [hsvrgb_pkg::SEC_W-1:0] sector,
  input  logic [$clog2((hsvrgb_pkg::DEG_PER_SECT << HUE_FRAC_BITS) + 1)-1:0] frac,
  input  logic [hsvrgb_pkg::PCT_W-1:0] sat,
  input  logic [hsvrgb_pkg::PCT_W-1:0] bri,
  output logic [hsvrgb_pkg::NUM_CH-1:0][hsvrgb_pkg::DEN_BASE_W+HUE_FRAC_BITS-1:0] chan_num
);
  import hsvrgb_pkg::*;

  localparam int SECT   = DEG_PER_SECT << HUE_FRAC_BITS;
  localparam int SECT_W = $clog2(SECT + 1);
  localparam int DEN_W  = DEN_BASE_W + HUE_FRAC_BITS;

  // stage 2: v*s and v*(100-s)
  logic [VS_W-1:0]   vs_r, vm_r;
  logic [SEC_W-1:0]  sec2_r;
  logic [SECT_W-1:0] frac2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_PROD]) begin
      vs_r    <= VS_W'(bri) * VS_W'(sat);
      vm_r    <= VS_W'(bri) * VS_W'(PCT_W'(PCT_MAX) - sat);
      sec2_r  <= sector;
      frac2_r <= frac;
    end
  end

  // stage 3: chroma, ramp and offset numerators over den
  logic [DEN_W-1:0] cn_r, xn_r, mn_r;
  logic [SEC_W-1:0] sec3_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_SCALE]) begin
      cn_r   <= DEN_W'(vs_r) * DEN_W'(SECT);
      xn_r   <= DEN_W'(vs_r) * DEN_W'(frac2_r);
      mn_r   <= DEN_W'(vm_r) * DEN_W'(SECT);
      sec3_r <= sec2_r;
    end
  end

  // stage 4: place c and x by sector, add m
  logic [DEN_W-1:0] rsel, gsel, bsel;
  logic [NUM_CH-1:0][DEN_W-1:0] num_r;

  always_comb begin
    rsel = '0;
    gsel = '0;
    bsel = '0;
    case (sec3_r)
      SEC_R_TO_Y: begin rsel = cn_r; gsel = xn_r; end
      SEC_Y_TO_G: begin rsel = xn_r; gsel = cn_r; end
      SEC_G_TO_C: begin gsel = cn_r; bsel = xn_r; end
      SEC_C_TO_B: begin gsel = xn_r; bsel = cn_r; end
      SEC_B_TO_M: begin rsel = xn_r; bsel = cn_r; end
      SEC_M_TO_R: begin rsel = cn_r; bsel = xn_r; end
      default: begin rsel = cn_r; bsel = xn_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_MIX]) begin
      num_r[CH_R] <= rsel + mn_r;
      num_r[CH_G] <= gsel + mn_r;
      num_r[CH_B] <= bsel + mn_r;
    end
  end

  assign chan_num = num_r;

endmodule

[rtl/hsvrgb_quant.sv]
module hsvrgb_quant #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  hsvrgb_pkg::pipe_ctl_t ctl,
  input  logic [hsvrgb_pkg::NUM_CH-1:0][hsvrgb_pkg::DEN_BASE_W+HUE_FRAC_BITS-1:0] chan_num,
  output logic [hsvrgb_pkg::RGB_W-1:0] rgb565
);
  import hsvrgb_pkg::*;

  localparam int     DEN_W  = DEN_BASE_W + HUE_FRAC_BITS;
  localparam int     P_W    = DEN_W + SCALE_W;
  localparam longint DEN    = longint'(DEN_BASE) << HUE_FRAC_BITS;
  localparam int     PSH    = HUE_FRAC_BITS + DEN_SH;
  localparam int     PROD_W = QN_W + RND_RCP_W;

  // stage 5: 510*num + den, drop the power-of-two part of 2*den
  logic [NUM_CH-1:0][P_W-1:0]  pnum;
  logic [NUM_CH-1:0][QN_W-1:0] qn_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pnum[c] = P_W'(chan_num[c]) * P_W'(CHAN_SCALE) + P_W'(DEN);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_RND]) begin
      for (int c = 0; c < NUM_CH; c++) begin
        qn_r[c] <= QN_W'(pnum[c] >> PSH);
      end
    end
  end

  // stage 6: divide by 9375 via reciprocal (exact over the qn range), pack
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  logic [NUM_CH-1:0][QCH_W-1:0]  q9;
  logic [NUM_CH-1:0][CH_W-1:0]   ch8;
  logic [RGB_W-1:0]              rgb_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(qn_r[c]) * PROD_W'(RND_RCP);
      q9[c]   = prod[c][RND_SH +: QCH_W];
      ch8[c]  = (q9[c] > QCH_W'(CH_MAX)) ? CH_W'(CH_MAX) : q9[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[STG_OUT]) begin
      rgb_r <= {ch8[CH_R][CH_W-1:3], ch8[CH_G][CH_W-1:2], ch8[CH_B][CH_W-1:3]};
    end
  end

  assign rgb565 = rgb_r;

endmodule

[rtl/hsv_to_rgb565.sv]
// HSV to RGB565 color converter.
// in_hsv (sink): one request per color, hue in 1/2^HUE_FRAC_BITS degree units
//   (signed, any value, wrapped into 0..360 deg), saturation and brightness
//   in percent (values above 100 read as 100).
// out_rgb (source): one packed RGB565 word per request, in request order.
// Both channels use valid/ready; a transfer happens when both are high.
// Path: an accepted request moves in order through seven register stages
//   (hue wrap, sector, v*s, numerators, mix, rounding, output reg), each
//   holding one request; the output reg drives out_rgb.valid. Throughput:
//   one request per clock while out_rgb.ready does not stall the pipe.
// Stalls: per-stage ready chain. A stage loads when it is empty or the next
//   stage loads, so bubbles close up and in_hsv.ready stays high until all
//   seven stages hold a request behind a stalled out_rgb.ready.
// Reset: synchronous, active-low rst_n clears all stage valid bits; the
//   datapath registers are not reset. No configuration and no retained state.
// Rounding: each 8-bit channel is exact round-half-up of (chan + m) * 255,
//   then red/blue keep 5 MSBs and green keeps 6 MSBs.
module hsv_to_rgb565 #(
  parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hsvrgb_in_if.sink   in_hsv,
  hsvrgb_out_if.source out_rgb
);
  import hsvrgb_pkg::*;

  localparam int SECT_W = $clog2((DEG_PER_SECT << HUE_FRAC_BITS) + 1);
  localparam int DEN_W  = DEN_BASE_W + HUE_FRAC_BITS;
  localparam int LAST   = NUM_STG - 1;

  // stage valid bits and load enables
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] ld;
  pipe_ctl_t          ctl;

  always_comb begin
    ld[LAST] = !vld_r[LAST] || out_rgb.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign ctl.ld       = ld;
  assign in_hsv.ready = ld[0];
  assign out_rgb.valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_hsv.valid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // datapath
  logic [SEC_W-1:0]                sector;
  logic [SECT_W-1:0]               frac;
  logic [PCT_W-1:0]                sat, bri;
  logic [NUM_CH-1:0][DEN_W-1:0]    chan_num;
  logic [RGB_W-1:0]                rgb565;

  hsvrgb_hue #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_hue (
    .clk        (clk),
    .ctl        (ctl),
    .hue        (in_hsv.hue),
    .saturation (in_hsv.saturation),
    .brightness (in_hsv.brightness),
    .sector     (sector),
    .frac       (frac),
    .sat        (sat),
    .bri        (bri)
  );

  hsvrgb_mix #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_mix (
    .clk      (clk),
    .ctl      (ctl),
    .sector   (sector),
    .frac     (frac),
    .sat      (sat),
    .bri      (bri),
    .chan_num (chan_num)
  );

  hsvrgb_quant #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_quant (
    .clk      (clk),
    .ctl      (ctl),
    .chan_num (chan_num),
    .rgb565   (rgb565)
  );

  assign out_rgb.rgb565 = rgb565;

  // a stage only holds back while it carries a request
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (~ld & ~vld_r) == '0)
    else $error("stage stalled while empty");

  // an empty output stage means the whole pipe can take a request
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[LAST] |-> in_hsv.ready)
    else $error("input blocked with empty output stage");

  // accepted request shows up in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_hsv.valid && in_hsv.ready) |=> vld_r[0])
    else $error("accepted request lost at entry");

  // after the output moves, it carries what the previous stage held
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && out_rgb.ready) |=> (vld_r[LAST] == $past(vld_r[LAST-1])))
    else $error("output stage did not advance");

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvrgb_pkg::*;

  // One sector is 60 degrees in hue units and a full turn is six sectors.
  // The denominator of every channel term is 100 * 100 * sector.
  localparam int HUE_SECTOR  = DEG_PER_SECT << HUE_FRAC_BITS_DEF;
  localparam int HUE_TURN    = HUE_SECTOR * NUM_SECT;
  localparam int HUE_LOW     = -HUE_TURN;
  localparam int HUE_HIGH    = HUE_TURN - 1;
  localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 90;     // long receiver hold-off, fills the pipe
  localparam int SETTLE      = 4 * NUM_STG;

  // One color request as it goes into the block.
  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [PCT_W-1:0]        saturation;
    logic [PCT_W-1:0]        brightness;
  } hsv_req_t;

  // Accepted request together with the packed color it must produce.
  typedef struct packed {
    hsv_req_t         req;
    logic [RGB_W-1:0] rgb;
  } color_check_t;

  logic clk;
  logic rst_n;

  hsvrgb_in_if  in_hsv();
  hsvrgb_out_if out_rgb();

  hsv_to_rgb565 uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_hsv  (in_hsv),
    .out_rgb (out_rgb)
  );

  color_check_t pending_colors[$];   // oldest accepted request first
  int           mismatch_count;
  int           quiet_cycles;

  // Receiver control, shared between the test tasks and the ready process.
  bit          rx_stalls_on;   // random ready bursts enabled
  int unsigned rx_hold_len;    // request for one long hold-off
  bit          rx_holding;     // hold-off in progress

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Exact round-half-up of num * 255 / den, clamped to 8 bits.
  function automatic logic [CH_W-1:0] round_channel(input longint unsigned num,
                                                    input longint unsigned den);
    longint unsigned q;
    q = (num * CHAN_SCALE + den) / (den * 2);
    return (q > CH_MAX) ? CH_W'(CH_MAX) : q[CH_W-1:0];
  endfunction

  function automatic logic [RGB_W-1:0] predict_rgb565(input hsv_req_t req);
    int               wrapped;
    int unsigned      s, v, pos, fold, rise;
    logic [SEC_W-1:0] sec;
    longint unsigned  cn, xn, mn, den, rn, gn, bn;
    logic [CH_W-1:0]  r, g, b;
    // true modulo: negative hues wrap upward into one turn
    wrapped = $signed(req.hue);
    wrapped = wrapped % HUE_TURN;
    if (wrapped < 0) wrapped += HUE_TURN;
    // percent fields above 100 read as 100
    s = (req.saturation > PCT_MAX) ? PCT_MAX : req.saturation;
    v = (req.brightness > PCT_MAX) ? PCT_MAX : req.brightness;

    sec  = SEC_W'(wrapped / HUE_SECTOR);
    pos  = wrapped % (2 * HUE_SECTOR);
    fold = (pos >= HUE_SECTOR) ? pos - HUE_SECTOR : HUE_SECTOR - pos;
    rise = HUE_SECTOR - fold;   // x as a fraction of one sector

    cn  = 64'(v) * s * HUE_SECTOR;
    xn  = 64'(v) * s * rise;
    mn  = 64'(v) * HUE_SECTOR * (PCT_MAX - s);
    den = 64'(PCT_MAX) * PCT_MAX * HUE_SECTOR;

    rn = 0;
    gn = 0;
    bn = 0;
    case (sec)
      SEC_R_TO_Y: begin rn = cn; gn = xn; end
      SEC_Y_TO_G: begin rn = xn; gn = cn; end
      SEC_G_TO_C: begin gn = cn; bn = xn; end
      SEC_C_TO_B: begin gn = xn; bn = cn; end
      SEC_B_TO_M: begin rn = xn; bn = cn; end
      default:    begin rn = cn; bn = xn; end
    endcase

    r = round_channel(rn + mn, den);
    g = round_channel(gn + mn, den);
    b = round_channel(bn + mn, den);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Drives one request at the falling edge and holds it until accepted.
  // Returns just after the accepting rising edge; valid stays high so a
  // following request goes out back to back.
  task automatic send_color(input hsv_req_t req);
    color_check_t entry;
    @(negedge clk);
    in_hsv.valid      <= 1'b1;
    in_hsv.hue        <= req.hue;
    in_hsv.saturation <= req.saturation;
    in_hsv.brightness <= req.brightness;
    @(posedge clk);
    while (!in_hsv.ready) @(posedge clk);
    entry.req = req;
    entry.rgb = predict_rgb565(req);
    pending_colors.push_back(entry);
  endtask

  // Sender gap: valid low for the given number of cycles.
  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_hsv.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    pause_sender(1);
    while (pending_colors.size() != 0) pause_sender(1);
  endtask

  function automatic hsv_req_t make_color(input int hue, input int sat, input int bright);
    hsv_req_t req;
    req.hue        = hue[HUE_W-1:0];
    req.saturation = sat[PCT_W-1:0];
    req.brightness = bright[PCT_W-1:0];
    return req;
  endfunction

  // Percent values at the interesting spots, including over-range ones.
  function automatic int corner_pct();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return 1;
      2:       return 50;
      3:       return 99;
      4:       return PCT_MAX;
      5:       return PCT_MAX + 1;
      default: return (1 << PCT_W) - 1;
    endcase
  endfunction

  // Mostly legal colors; some raw 14/7-bit noise so every input bit toggles;
  // some hues on or next to sector boundaries (including wrapped ones).
  function automatic hsv_req_t random_color();
    int pick;
    int h;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      h = HUE_LOW + int'($urandom_range(0, HUE_HIGH - HUE_LOW));
      return make_color(h, $urandom_range(0, PCT_MAX), $urandom_range(0, PCT_MAX));
    end else if (pick == 7) begin
      return make_color($urandom(), $urandom(), $urandom());
    end else begin
      h = (int'($urandom_range(0, 16)) - 8) * HUE_SECTOR + int'($urandom_range(0, 2)) - 1;
      return make_color(h, corner_pct(), corner_pct());
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Ready driver: random stall and ready bursts, or one long hold-off when a
  // test asks for it. The hold-off length is counted here, not by the sender.
  initial begin : ready_driver
    int unsigned n;
    out_rgb.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_len != 0) begin
        n           = rx_hold_len;
        rx_hold_len = 0;
        rx_holding  = 1'b1;
        repeat (n) begin
          @(negedge clk);
          out_rgb.ready <= 1'b0;
        end
        rx_holding = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 18);
        repeat (n) begin
          @(negedge clk);
          out_rgb.ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk);
          out_rgb.ready <= 1'b1;
        end
      end
    end
  end

  // Result checker: every accepted word against the oldest prediction.
  always @(posedge clk) begin : check_results
    color_check_t head;
    if (rst_n && out_rgb.valid && out_rgb.ready) begin
      if (pending_colors.size() == 0) begin
        $error("rgb565: result with no request pending, got %h", out_rgb.rgb565);
        mismatch_count++;
      end else begin
        head = pending_colors.pop_front();
        if (out_rgb.rgb565 !== head.rgb) begin
          $error("rgb565 mismatch (hue %0d sat %0d bright %0d): expected %h, got %h",
                 head.req.hue, head.req.saturation, head.req.brightness,
                 head.rgb, out_rgb.rgb565);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: consecutive cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_hsv.valid && in_hsv.ready) || (out_rgb.valid && out_rgb.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, wrap cases, every sector start and the percent clamp.
  task automatic test_directed();
    hsv_req_t reqs[$];
    int       k;
    reqs.push_back(make_color(0, PCT_MAX, PCT_MAX));                // pure red
    reqs.push_back(make_color(0, 0, 0));                            // black
    reqs.push_back(make_color(0, 0, PCT_MAX));                      // white
    for (k = 1; k < NUM_SECT; k++)
      reqs.push_back(make_color(k * HUE_SECTOR, PCT_MAX, PCT_MAX)); // sector starts
    reqs.push_back(make_color(HUE_SECTOR - 1, PCT_MAX, PCT_MAX));   // just below boundary
    reqs.push_back(make_color(HUE_HIGH, PCT_MAX, PCT_MAX));         // just below a full turn
    reqs.push_back(make_color(HUE_LOW, PCT_MAX, PCT_MAX));          // -360 deg wraps to 0
    reqs.push_back(make_color(-1, 77, 63));                         // small negative hue
    reqs.push_back(make_color(-(1 << (HUE_W - 1)), 50, 50));        // most negative code
    reqs.push_back(make_color((1 << (HUE_W - 1)) - 1, 50, 50));     // most positive code
    reqs.push_back(make_color(HUE_TURN, 100, 100));                 // out of range, wraps
    reqs.push_back(make_color(3 * HUE_SECTOR / 2, 100, 50));        // mid sector
    reqs.push_back(make_color(1234, PCT_MAX + 1, PCT_MAX + 1));     // clamp just above 100
    reqs.push_back(make_color(2222, (1 << PCT_W) - 1, (1 << PCT_W) - 1));
    reqs.push_back(make_color(4000, 1, 1));
    reqs.push_back(make_color(500, 33, 99));
    reqs.push_back(make_color(-3000, 0, 100));                      // gray path, s = 0
    foreach (reqs[i]) send_color(reqs[i]);
    wait_until_drained();
  endtask

  // Bulk random colors, chunks with and without sender gaps.
  task automatic test_random_colors(input int count);
    bit gaps_on;
    int i;
    gaps_on = 1'b1;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (gaps_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 18));
      send_color(random_color());
    end
  endtask

  // Receiver holds off long enough that all stages fill and the input stalls,
  // while the sender keeps offering requests.
  task automatic test_backpressure();
    int i;
    rx_hold_len = HOLD_CYCLES;
    pause_sender(1);
    while (!rx_holding) pause_sender(1);
    for (i = 0; i < 3 * NUM_STG; i++) send_color(random_color());
  endtask

  // Sender stops until every outstanding request has come back, then resumes.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 10; i++) send_color(random_color());
    wait_until_drained();
    for (i = 0; i < 10; i++) send_color(random_color());
  endtask

  // Closing stretch at full rate, no gaps on either side.
  task automatic test_streaming(input int count);
    int i;
    rx_stalls_on = 1'b0;
    for (i = 0; i < count; i++) send_color(random_color());
  endtask

  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    rx_stalls_on   = 1'b1;
    rx_hold_len    = 0;
    rx_holding     = 1'b0;

    // all block inputs known from time zero
    rst_n             <= 1'b0;
    in_hsv.valid      <= 1'b0;
    in_hsv.hue        <= '0;
    in_hsv.saturation <= '0;
    in_hsv.brightness <= '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_colors(1100);
    test_backpressure();
    test_drain_pause();
    test_random_colors(60);
    test_streaming(330);

    wait_until_drained();
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0 && pending_colors.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
